// ===== src/ircbg_pkg.sv =====
package ircbg_pkg;

    // Field widths
    localparam int DUR_W      = 20;
    localparam int SEG_W      = 16;
    localparam int PHASE_W    = 32;
    localparam int STEP_W     = 31;
    localparam int GAIN_W     = 16;
    localparam int SAMPLE_W   = 16;
    localparam int MAG_W      = 15;
    localparam int CFG_DATA_W = 31;
    localparam int CFG_IDX_W  = 1;

    // Timing and sine table geometry
    localparam int SINE_TABLE_BITS = 10;
    localparam int QUARTER_BITS    = SINE_TABLE_BITS - 2;
    localparam int QUARTER         = 1 << QUARTER_BITS;
    localparam int SAMPLE_RATE     = 44100;
    localparam int PREAMBLE_US     = 25000;
    localparam int US_PER_S        = 1000000;
    localparam int ROUND_BIAS      = US_PER_S / 2;

    // Serial converter sizing: the product register also holds the divider remainder.
    localparam int PROD_W  = DUR_W + $clog2(SAMPLE_RATE) + 1;
    localparam int REM_W   = $clog2(US_PER_S);
    localparam int UP_W    = PROD_W - SEG_W;
    localparam int CNT_W   = $clog2(DUR_W);
    localparam longint SEG_MAX = (longint'(1) << SEG_W) - 1;

    // Preamble length in samples, rounded and saturated like any other segment.
    localparam longint PREAMBLE_RAW =
        (longint'(PREAMBLE_US) * SAMPLE_RATE + ROUND_BIAS) / US_PER_S;
    localparam logic [SEG_W-1:0] PREAMBLE_SAMPLES =
        (PREAMBLE_RAW > SEG_MAX) ? SEG_W'(SEG_MAX) : SEG_W'(PREAMBLE_RAW);

    // Gain in Q1.15
    localparam int GAIN_SHIFT = 15;
    localparam logic [GAIN_W-1:0] GAIN_FULL = GAIN_W'(1 << GAIN_SHIFT);

    // Reset values of the configuration registers
    localparam logic [STEP_W-1:0] PHASE_STEP_RESET = STEP_W'(1850439415);
    localparam logic [GAIN_W-1:0] GAIN_RESET       = GAIN_FULL;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_GAIN       = CFG_IDX_W'(1);

    // Command codes
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_PUSH  = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_DUR,
        ST_DIV,
        ST_LOAD,
        ST_TICK,
        ST_MUL_GAIN,
        ST_DONE
    } state_t;

    // Fixed-point sine series constants
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1073741824;

    typedef logic [MAG_W-1:0] sine_rom_t [0:QUARTER-1];

    // Magnitude round(32767 * sin(m * (pi/2) / QUARTER)) by a truncated Taylor series.
    function automatic logic [MAG_W-1:0] sine_mag(input int unsigned m);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] s;
        x    = (64'(m) * HALF_PI_Q30) >> QUARTER_BITS;
        x2   = (x * x) >> 30;
        term = x;
        pos  = x;
        neg  = 64'd0;
        term = ((term * x2) >> 30) / 64'd6;
        neg  = neg + term;
        term = ((term * x2) >> 30) / 64'd20;
        pos  = pos + term;
        term = ((term * x2) >> 30) / 64'd42;
        neg  = neg + term;
        term = ((term * x2) >> 30) / 64'd72;
        pos  = pos + term;
        term = ((term * x2) >> 30) / 64'd110;
        neg  = neg + term;
        term = ((term * x2) >> 30) / 64'd156;
        pos  = pos + term;
        s = (neg > pos) ? 64'd0 : pos - neg;
        if (s > ONE_Q30)
        begin
            s = ONE_Q30;
        end
        return MAG_W'((64'd32767 * s + (ONE_Q30 >> 1)) >> 30);
    endfunction

    function automatic sine_rom_t sine_rom_build();
        sine_rom_t t;
        for (int k = 0; k < QUARTER; k++)
        begin
            t[k] = sine_mag(k);
        end
        return t;
    endfunction

    // Quarter-wave table; the peak entry at a full quarter is kept apart.
    localparam sine_rom_t        SINE_ROM  = sine_rom_build();
    localparam logic [MAG_W-1:0] SINE_PEAK = sine_mag(QUARTER);

endpackage

// ===== src/ir_carrier_burst_generator_top.sv =====
// Channel   Direction  Signals                                         Beat
// in        sink       in_valid, in_ready, cmd, duration_us            one command
// out       source     out_valid, out_ready, sample_left, sample_right,
//                      sample_valid, is_mark, need_duration            one result
// cfg       sink       cfg_valid, cfg_ready, cfg_index, cfg_data       one register write
//
// Every input beat gives exactly one output beat. A push or start goes straight to the
// result; a tick passes the tick state, and a mark tick then takes 16 gain multiply steps
// of the bit-serial adder. A beat that loads a new segment first takes 20 multiply and
// 16 divide steps to convert microseconds into samples, then passes the load state.
// One command is worked at a time; the next is taken while the last result waits.
// Reset clears the segment state and restores the register defaults; cfg is always ready.
module ir_carrier_burst_generator_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          cmd,
    input  logic [ircbg_pkg::DUR_W-1:0]         duration_us,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [ircbg_pkg::SAMPLE_W-1:0] sample_left,
    output logic signed [ircbg_pkg::SAMPLE_W-1:0] sample_right,
    output logic                                sample_valid,
    output logic                                is_mark,
    output logic                                need_duration,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ircbg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ircbg_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int PROD_W   = ircbg_pkg::PROD_W;
    localparam int SEG_W    = ircbg_pkg::SEG_W;
    localparam int REM_W    = ircbg_pkg::REM_W;
    localparam int UP_W     = ircbg_pkg::UP_W;
    localparam int CNT_W    = ircbg_pkg::CNT_W;
    localparam int DUR_W    = ircbg_pkg::DUR_W;
    localparam int GAIN_W   = ircbg_pkg::GAIN_W;
    localparam int SAMPLE_W = ircbg_pkg::SAMPLE_W;
    localparam int PHASE_W  = ircbg_pkg::PHASE_W;
    localparam int STEP_W   = ircbg_pkg::STEP_W;
    localparam int MAG_W    = ircbg_pkg::MAG_W;
    localparam int QB       = ircbg_pkg::QUARTER_BITS;
    localparam int TB       = ircbg_pkg::SINE_TABLE_BITS;

    // Control state
    ircbg_pkg::state_t    state_reg, state_next;
    logic                 out_valid_reg, out_valid_next;
    logic [SEG_W-1:0]     remaining_reg, remaining_next;
    logic                 level_reg, level_next;
    logic [PHASE_W-1:0]   phase_reg, phase_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic                 active_reg, active_next;
    logic [STEP_W-1:0]    phase_step_reg;
    logic [GAIN_W-1:0]    gain_reg;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;

    // Datapath registers
    logic [1:0]           cmd_reg, cmd_next;
    logic [DUR_W-1:0]     pend_dur_reg, pend_dur_next;
    logic [PROD_W-1:0]    prod_reg, prod_next;
    logic [PROD_W-1:0]    mcand_reg, mcand_next;
    logic [DUR_W-1:0]     mplier_reg, mplier_next;
    logic                 neg_reg, neg_next;
    logic                 sat_reg, sat_next;
    logic [SAMPLE_W-1:0]  res_left_reg, res_left_next;
    logic                 res_valid_reg, res_valid_next;
    logic                 res_mark_reg, res_mark_next;
    logic [SAMPLE_W-1:0]  out_left_reg;
    logic [SAMPLE_W-1:0]  out_right_reg;
    logic                 out_svalid_reg;
    logic                 out_mark_reg;
    logic                 out_need_reg;

    // Shared helpers
    logic                 in_fire;
    logic                 out_load;
    logic [PROD_W-1:0]    prod_add;
    logic [REM_W:0]       div_trial;
    logic                 div_ge;
    logic [REM_W-1:0]     div_rem;
    logic [TB-1:0]        sine_k;
    logic [1:0]           sine_q;
    logic [QB-1:0]        sine_r;
    logic [QB-1:0]        sine_mirror;
    logic [MAG_W-1:0]     sine_mag;
    logic [GAIN_W-1:0]    gain_clamped;
    logic [SAMPLE_W-1:0]  prod_scaled;
    logic                 load_now;

    assign in_fire  = in_valid && in_ready;
    assign out_load = (state_reg == ircbg_pkg::ST_DONE) && (!out_valid_reg || out_ready);

    // Shift-add step shared by the duration and gain multiplies.
    assign prod_add = prod_reg + (mplier_reg[0] ? mcand_reg : PROD_W'(0));

    // Restoring divide step by one million: remainder sits above the quotient bits.
    assign div_trial = {prod_reg[SEG_W +: REM_W], prod_reg[SEG_W-1]};
    assign div_ge    = div_trial >= (REM_W+1)'(ircbg_pkg::US_PER_S);
    assign div_rem   = div_ge ? REM_W'(div_trial - (REM_W+1)'(ircbg_pkg::US_PER_S))
                              : div_trial[REM_W-1:0];

    // Quarter-wave sine lookup from the top phase bits.
    assign sine_k      = phase_reg[PHASE_W-1 -: TB];
    assign sine_q      = sine_k[TB-1 -: 2];
    assign sine_r      = sine_k[QB-1:0];
    assign sine_mirror = QB'(ircbg_pkg::QUARTER - int'(sine_r));
    assign sine_mag    = (sine_q[0] && (sine_r == '0)) ? ircbg_pkg::SINE_PEAK
                       : ircbg_pkg::SINE_ROM[sine_q[0] ? sine_mirror : sine_r];

    assign gain_clamped = (gain_reg > ircbg_pkg::GAIN_FULL) ? ircbg_pkg::GAIN_FULL : gain_reg;
    assign prod_scaled  = prod_add[ircbg_pkg::GAIN_SHIFT +: SAMPLE_W];

    // A tick loads the next segment when the current one is used up.
    assign load_now = (remaining_reg == '0) && active_reg && pend_valid_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ircbg_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    priority case (cmd)
                        ircbg_pkg::CMD_PUSH:
                            state_next = ((remaining_reg == '0) && active_reg)
                                       ? ircbg_pkg::ST_MUL_DUR : ircbg_pkg::ST_DONE;
                        ircbg_pkg::CMD_TICK:
                            state_next = load_now ? ircbg_pkg::ST_MUL_DUR
                                                  : ircbg_pkg::ST_TICK;
                        default:
                            state_next = ircbg_pkg::ST_DONE;
                    endcase
                end
            end
            ircbg_pkg::ST_MUL_DUR:
            begin
                if (cnt_reg == CNT_W'(DUR_W - 1))
                begin
                    state_next = ircbg_pkg::ST_DIV;
                end
            end
            ircbg_pkg::ST_DIV:
            begin
                if (cnt_reg == CNT_W'(SEG_W - 1))
                begin
                    state_next = ircbg_pkg::ST_LOAD;
                end
            end
            ircbg_pkg::ST_LOAD:
            begin
                state_next = (cmd_reg == ircbg_pkg::CMD_TICK) ? ircbg_pkg::ST_TICK
                                                              : ircbg_pkg::ST_DONE;
            end
            ircbg_pkg::ST_TICK:
            begin
                state_next = ((remaining_reg != '0) && level_reg) ? ircbg_pkg::ST_MUL_GAIN
                                                                  : ircbg_pkg::ST_DONE;
            end
            ircbg_pkg::ST_MUL_GAIN:
            begin
                if (cnt_reg == CNT_W'(GAIN_W - 1))
                begin
                    state_next = ircbg_pkg::ST_DONE;
                end
            end
            ircbg_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ircbg_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ircbg_pkg::ST_IDLE;
            end
        endcase
    end

    // Handshake outputs
    assign in_ready  = (state_reg == ircbg_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;

    // Datapath and segment state updates
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        remaining_next  = remaining_reg;
        level_next      = level_reg;
        phase_next      = phase_reg;
        pend_valid_next = pend_valid_reg;
        active_next     = active_reg;
        cnt_next        = cnt_reg;
        cmd_next        = cmd_reg;
        pend_dur_next   = pend_dur_reg;
        prod_next       = prod_reg;
        mcand_next      = mcand_reg;
        mplier_next     = mplier_reg;
        neg_next        = neg_reg;
        sat_next        = sat_reg;
        res_left_next   = res_left_reg;
        res_valid_next  = res_valid_reg;
        res_mark_next   = res_mark_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ircbg_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    cmd_next       = cmd;
                    res_left_next  = '0;
                    res_valid_next = 1'b0;
                    res_mark_next  = 1'b0;
                    cnt_next       = '0;
                    prod_next      = PROD_W'(ircbg_pkg::ROUND_BIAS);
                    mcand_next     = PROD_W'(ircbg_pkg::SAMPLE_RATE);
                    mplier_next    = pend_dur_reg;
                    priority case (cmd)
                        ircbg_pkg::CMD_START:
                        begin
                            pend_valid_next = 1'b0;
                            level_next      = 1'b0;
                            active_next     = 1'b1;
                            remaining_next  = ircbg_pkg::PREAMBLE_SAMPLES;
                            phase_next      = PHASE_W'(phase_step_reg >> 1);
                        end
                        ircbg_pkg::CMD_PUSH:
                        begin
                            if (!pend_valid_reg)
                            begin
                                pend_dur_next = duration_us;
                                mplier_next   = duration_us;
                            end
                            pend_valid_next = 1'b1;
                        end
                        default:
                        begin
                            pend_valid_next = pend_valid_reg;
                        end
                    endcase
                end
            end
            ircbg_pkg::ST_MUL_DUR:
            begin
                prod_next   = prod_add;
                mcand_next  = {mcand_reg[PROD_W-2:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[DUR_W-1:1]};
                cnt_next    = (cnt_reg == CNT_W'(DUR_W - 1)) ? '0 : cnt_reg + 1'b1;
            end
            ircbg_pkg::ST_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    sat_next = prod_reg[PROD_W-1:SEG_W] >= UP_W'(ircbg_pkg::US_PER_S);
                end
                prod_next = {UP_W'(div_rem), prod_reg[SEG_W-2:0], div_ge};
                cnt_next  = cnt_reg + 1'b1;
            end
            ircbg_pkg::ST_LOAD:
            begin
                level_next      = !level_reg;
                remaining_next  = sat_reg ? SEG_W'(ircbg_pkg::SEG_MAX) : prod_reg[SEG_W-1:0];
                phase_next      = PHASE_W'(phase_step_reg >> 1);
                pend_valid_next = 1'b0;
            end
            ircbg_pkg::ST_TICK:
            begin
                cnt_next    = '0;
                prod_next   = '0;
                mcand_next  = PROD_W'(sine_mag);
                mplier_next = DUR_W'(gain_clamped);
                neg_next    = sine_q[1];
                if (remaining_reg != '0)
                begin
                    res_valid_next = 1'b1;
                    res_mark_next  = level_reg;
                    remaining_next = remaining_reg - 1'b1;
                    phase_next     = phase_reg + PHASE_W'(phase_step_reg);
                end
            end
            ircbg_pkg::ST_MUL_GAIN:
            begin
                prod_next   = prod_add;
                mcand_next  = {mcand_reg[PROD_W-2:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[DUR_W-1:1]};
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(GAIN_W - 1))
                begin
                    res_left_next = neg_reg ? SAMPLE_W'(-prod_scaled) : prod_scaled;
                end
            end
            ircbg_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                cnt_next = '0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ircbg_pkg::ST_IDLE;
            out_valid_reg  <= 1'b0;
            remaining_reg  <= '0;
            level_reg      <= 1'b0;
            phase_reg      <= '0;
            pend_valid_reg <= 1'b0;
            active_reg     <= 1'b0;
            cnt_reg        <= '0;
            phase_step_reg <= ircbg_pkg::PHASE_STEP_RESET;
            gain_reg       <= ircbg_pkg::GAIN_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            remaining_reg  <= remaining_next;
            level_reg      <= level_next;
            phase_reg      <= phase_next;
            pend_valid_reg <= pend_valid_next;
            active_reg     <= active_next;
            cnt_reg        <= cnt_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    ircbg_pkg::REG_PHASE_STEP: phase_step_reg <= cfg_data[STEP_W-1:0];
                    ircbg_pkg::REG_GAIN:       gain_reg       <= cfg_data[GAIN_W-1:0];
                    default:                   gain_reg       <= gain_reg;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        pend_dur_reg  <= pend_dur_next;
        prod_reg      <= prod_next;
        mcand_reg     <= mcand_next;
        mplier_reg    <= mplier_next;
        neg_reg       <= neg_next;
        sat_reg       <= sat_next;
        res_left_reg  <= res_left_next;
        res_valid_reg <= res_valid_next;
        res_mark_reg  <= res_mark_next;
        if (out_load)
        begin
            out_left_reg   <= res_left_reg;
            out_right_reg  <= SAMPLE_W'(-res_left_reg);
            out_svalid_reg <= res_valid_reg;
            out_mark_reg   <= res_mark_reg;
            out_need_reg   <= !pend_valid_reg;
        end
    end

    // Output port drive
    assign out_valid     = out_valid_reg;
    assign sample_left   = out_left_reg;
    assign sample_right  = out_right_reg;
    assign sample_valid  = out_svalid_reg;
    assign is_mark       = out_mark_reg;
    assign need_duration = out_need_reg;

    // A silent or idle result never carries a sample value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !sample_valid) |-> (sample_left == '0))
        else $error("nonzero sample on an invalid result");

    // The mark flag only comes with a valid sample.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && is_mark) |-> sample_valid)
        else $error("mark flagged without a sample");

    // A segment load always empties the pending slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ircbg_pkg::ST_LOAD) |=> !pend_valid_reg)
        else $error("pending duration survived a segment load");

    // An accepted command always leaves the idle state.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg != ircbg_pkg::ST_IDLE))
        else $error("accepted command was not processed");

    // The serial step counter stays inside the longest operand.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ircbg_pkg::ST_MUL_DUR || state_reg == ircbg_pkg::ST_DIV ||
         state_reg == ircbg_pkg::ST_MUL_GAIN) |-> (cnt_reg < CNT_W'(DUR_W)))
        else $error("serial step counter out of range");

endmodule

// ===== tb/ir_carrier_burst_generator_top_test.sv =====
`timescale 1ns / 1ps

module ir_carrier_burst_generator_top_test;

    localparam int SAMPLE_W        = ircbg_pkg::SAMPLE_W;
    localparam int DUR_W           = ircbg_pkg::DUR_W;
    localparam int SEG_W           = ircbg_pkg::SEG_W;
    localparam int PHASE_W         = ircbg_pkg::PHASE_W;
    localparam int STEP_W          = ircbg_pkg::STEP_W;
    localparam int GAIN_W          = ircbg_pkg::GAIN_W;
    localparam int MAG_W           = ircbg_pkg::MAG_W;
    localparam int CFG_IDX_W       = ircbg_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W      = ircbg_pkg::CFG_DATA_W;
    localparam int SINE_TABLE_BITS = ircbg_pkg::SINE_TABLE_BITS;
    localparam int QUARTER_BITS    = ircbg_pkg::QUARTER_BITS;

    localparam int CLK_HALF = 4;
    // Longest beat: a segment load plus a mark sample, with some margin.
    localparam int TAIL_CYCLES = 64;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DEEP_ITEMS = 150;
    localparam int MAX_PRINTS = 100;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // One expected output beat.
    typedef struct {
        logic signed [SAMPLE_W-1:0] left_smp;
        logic signed [SAMPLE_W-1:0] right_smp;
        logic active;
        logic mark;
        logic need_dur;
    } sample_beat_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [1:0] cmd = ircbg_pkg::CMD_START;
    logic [DUR_W-1:0] duration_us = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [SAMPLE_W-1:0] sample_left;
    logic signed [SAMPLE_W-1:0] sample_right;
    logic sample_valid;
    logic is_mark;
    logic need_duration;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = ircbg_pkg::REG_PHASE_STEP;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Mirror of the generator state and its registers.
    logic [STEP_W-1:0] step_cfg = ircbg_pkg::PHASE_STEP_RESET;
    logic [GAIN_W-1:0] gain_cfg = ircbg_pkg::GAIN_RESET;
    logic [SEG_W-1:0] seg_left = '0;
    logic level_hi = 1'b0;
    logic [PHASE_W-1:0] phase = '0;
    logic [DUR_W-1:0] pend_dur = '0;
    logic pend_ok = 1'b0;
    logic running = 1'b0;

    sample_beat_t samples_due[$];
    int errors = 0;
    int beats_sent = 0;
    int mark_ticks = 0;
    int silent_ticks = 0;
    int underruns = 0;
    int seg_loads = 0;
    int reg_writes = 0;
    logic quiet = 1'b0;
    int stall_request = 0;

    ir_carrier_burst_generator_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .cmd           (cmd),
        .duration_us   (duration_us),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .sample_left   (sample_left),
        .sample_right  (sample_right),
        .sample_valid  (sample_valid),
        .is_mark       (is_mark),
        .need_duration (need_duration),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #(CLK_HALF) clk = ~clk;

    // Microseconds to samples, rounded half up and saturated to the counter width.
    function automatic logic [SEG_W-1:0] samples_for(input logic [DUR_W-1:0] us);
        longint n;
        n = (longint'(us) * ircbg_pkg::SAMPLE_RATE + ircbg_pkg::ROUND_BIAS)
            / ircbg_pkg::US_PER_S;
        return (n > ircbg_pkg::SEG_MAX) ? SEG_W'(ircbg_pkg::SEG_MAX) : SEG_W'(n);
    endfunction

    // Quarter-wave magnitude from a fixed-point Taylor series in Q30.
    function automatic logic [MAG_W-1:0] carrier_mag(input int unsigned m);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] s;
        int n;
        x = (64'(m) * ircbg_pkg::HALF_PI_Q30) >> QUARTER_BITS;
        x2 = (x * x) >> 30;
        term = x;
        pos = x;
        neg = '0;
        for (n = 1; n <= 6; n++)
        begin
            term = ((term * x2) >> 30) / (64'(2 * n) * 64'(2 * n + 1));
            if (n % 2 == 1)
            begin
                neg = neg + term;
            end
            else
            begin
                pos = pos + term;
            end
        end
        s = (neg > pos) ? 64'd0 : pos - neg;
        if (s > ircbg_pkg::ONE_Q30)
        begin
            s = ircbg_pkg::ONE_Q30;
        end
        return MAG_W'((64'd32767 * s + (ircbg_pkg::ONE_Q30 >> 1)) >> 30);
    endfunction

    // Take the pending duration as the next segment once the current one has run out.
    function automatic void load_pending();
        if (seg_left == 0 && running && pend_ok)
        begin
            level_hi = ~level_hi;
            seg_left = samples_for(pend_dur);
            phase = PHASE_W'(step_cfg >> 1);
            pend_ok = 1'b0;
            seg_loads++;
        end
    endfunction

    // Apply one command to the mirrored state and return the beat it produces.
    function automatic sample_beat_t predict_sample(input logic [1:0] c,
                                                    input logic [DUR_W-1:0] d);
        sample_beat_t b;
        logic [SINE_TABLE_BITS-1:0] k;
        logic [QUARTER_BITS-1:0] r;
        logic [MAG_W-1:0] mag;
        logic [GAIN_W-1:0] g;
        logic [31:0] v;
        b.left_smp = '0;
        b.active = 1'b0;
        b.mark = 1'b0;
        case (c)
            ircbg_pkg::CMD_START:
            begin
                pend_ok = 1'b0;
                level_hi = 1'b0;
                running = 1'b1;
                seg_left = samples_for(DUR_W'(ircbg_pkg::PREAMBLE_US));
                phase = PHASE_W'(step_cfg >> 1);
            end
            ircbg_pkg::CMD_PUSH:
            begin
                if (!pend_ok)
                begin
                    pend_dur = d;
                    pend_ok = 1'b1;
                end
                load_pending();
            end
            ircbg_pkg::CMD_TICK:
            begin
                load_pending();
                if (seg_left != 0)
                begin
                    b.active = 1'b1;
                    b.mark = level_hi;
                    if (level_hi)
                    begin
                        k = phase[PHASE_W-1 -: SINE_TABLE_BITS];
                        r = k[QUARTER_BITS-1:0];
                        // Odd quarters run the table backwards, the upper half is negative.
                        mag = k[QUARTER_BITS] ? carrier_mag(ircbg_pkg::QUARTER - r)
                                              : carrier_mag(r);
                        g = (gain_cfg > ircbg_pkg::GAIN_FULL) ? ircbg_pkg::GAIN_FULL
                                                              : gain_cfg;
                        v = (32'(mag) * 32'(g)) >> ircbg_pkg::GAIN_SHIFT;
                        b.left_smp = k[SINE_TABLE_BITS-1] ? SAMPLE_W'(-v) : SAMPLE_W'(v);
                        mark_ticks++;
                    end
                    else
                    begin
                        silent_ticks++;
                    end
                    seg_left = seg_left - 1'b1;
                    phase = phase + PHASE_W'(step_cfg);
                end
                else
                begin
                    underruns++;
                end
            end
            default:
            begin
            end
        endcase
        b.right_smp = -b.left_smp;
        b.need_dur = ~pend_ok;
        return b;
    endfunction

    task automatic note_mismatch(input string what, input longint got_val,
                                 input longint exp_val);
        errors++;
        if (errors <= MAX_PRINTS)
        begin
            $display("mismatch at %0t ns: %s got %0d expected %0d",
                     $time, what, got_val, exp_val);
        end
    endtask

    // Send one command beat, with an occasional gap before it, and record its result.
    task automatic send_beat(input logic [1:0] c, input logic [DUR_W-1:0] d);
        if (!quiet && $urandom_range(99) < 10)
        begin
            in_valid <= 1'b0;
            do
            begin
                @(posedge clk);
            end
            while ($urandom_range(99) < 50);
        end
        in_valid <= 1'b1;
        cmd <= c;
        duration_us <= d;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        samples_due.push_back(predict_sample(c, d));
        beats_sent++;
    endtask

    // Stop sending and wait until every expected beat has come back.
    task automatic wait_until_quiet();
        in_valid <= 1'b0;
        while (samples_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // Write both registers back to back; only called while the generator is idle.
    task automatic write_regs(input logic [CFG_DATA_W-1:0] step_word,
                              input logic [CFG_DATA_W-1:0] gain_word);
        cfg_valid <= 1'b1;
        cfg_index <= ircbg_pkg::REG_PHASE_STEP;
        cfg_data <= step_word;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        step_cfg = step_word[STEP_W-1:0];
        cfg_index <= ircbg_pkg::REG_GAIN;
        cfg_data <= gain_word;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        gain_cfg = gain_word[GAIN_W-1:0];
        cfg_valid <= 1'b0;
        reg_writes += 2;
    endtask

    // Commands before any pattern has started, then a start that drops the stored duration.
    task automatic test_before_start();
        send_beat(ircbg_pkg::CMD_TICK, '0);
        send_beat(CMD_UNUSED, '1);
        send_beat(ircbg_pkg::CMD_PUSH, '1);
        send_beat(ircbg_pkg::CMD_PUSH, '0);
        send_beat(ircbg_pkg::CMD_TICK, '1);
        send_beat(ircbg_pkg::CMD_START, '1);
        send_beat(ircbg_pkg::CMD_TICK, '0);
        send_beat(CMD_UNUSED, '0);
    endtask

    // A full silent preamble, then a zero-length segment and ticks with nothing left.
    task automatic test_preamble();
        send_beat(ircbg_pkg::CMD_START, DUR_W'($urandom()));
        // The preamble runs with no gaps on either side.
        quiet = 1'b1;
        repeat (samples_for(DUR_W'(ircbg_pkg::PREAMBLE_US)))
            send_beat(ircbg_pkg::CMD_TICK, DUR_W'($urandom()));
        quiet = 1'b0;
        send_beat(ircbg_pkg::CMD_TICK, '0);
        send_beat(ircbg_pkg::CMD_PUSH, DUR_W'(11));
        send_beat(ircbg_pkg::CMD_TICK, '1);
    endtask

    // Short segments, a push while one is already pending, and a one-sample segment.
    task automatic test_segments();
        send_beat(ircbg_pkg::CMD_PUSH, DUR_W'(100));
        send_beat(ircbg_pkg::CMD_PUSH, DUR_W'(50));
        send_beat(ircbg_pkg::CMD_PUSH, DUR_W'(77));
        repeat (7) send_beat(ircbg_pkg::CMD_TICK, DUR_W'($urandom()));
        send_beat(ircbg_pkg::CMD_PUSH, DUR_W'(12));
        repeat (2) send_beat(ircbg_pkg::CMD_TICK, DUR_W'($urandom()));
    endtask

    // Register extremes, gain above full scale among them, each followed by a mark.
    task automatic test_register_extremes();
        logic [CFG_DATA_W-1:0] steps[5];
        logic [GAIN_W-1:0] gains[5];
        logic [CFG_DATA_W-1:0] gain_word;
        int i;
        steps = '{'0, '1, CFG_DATA_W'($urandom()), CFG_DATA_W'(1),
                  CFG_DATA_W'(ircbg_pkg::PHASE_STEP_RESET)};
        gains = '{'0, '1, ircbg_pkg::GAIN_FULL, GAIN_W'(1), GAIN_W'($urandom_range(32768))};
        for (i = 0; i < 5; i++)
        begin
            wait_until_quiet();
            gain_word = CFG_DATA_W'($urandom());
            gain_word[GAIN_W-1:0] = gains[i];
            write_regs(steps[i], gain_word);
            send_beat(ircbg_pkg::CMD_PUSH, DUR_W'(100));
            send_beat(ircbg_pkg::CMD_PUSH, DUR_W'(100));
            repeat (9) send_beat(ircbg_pkg::CMD_TICK, DUR_W'($urandom()));
        end
    endtask

    // The receiver holds off while commands keep coming, then the sender waits it out.
    task automatic test_back_pressure();
        stall_request = HOLD_OFF_CYCLES;
        send_beat(ircbg_pkg::CMD_PUSH, DUR_W'(300));
        send_beat(ircbg_pkg::CMD_PUSH, DUR_W'(300));
        repeat (18) send_beat(ircbg_pkg::CMD_TICK, DUR_W'($urandom()));
        wait_until_quiet();
    endtask

    // The longest duration, ticked briefly and cut off by a new start.
    task automatic test_long_segment();
        while (pend_ok)
        begin
            send_beat(ircbg_pkg::CMD_TICK, DUR_W'($urandom()));
        end
        send_beat(ircbg_pkg::CMD_PUSH, '1);
        repeat (8) send_beat(ircbg_pkg::CMD_TICK, DUR_W'($urandom()));
        send_beat(ircbg_pkg::CMD_START, '0);
    endtask

    // Random pattern: mostly well-formed pushes and ticks, some noise and starved ticks.
    task automatic test_random_patterns();
        int deep;
        int roll;
        logic [CFG_DATA_W-1:0] gain_word;
        logic [DUR_W-1:0] dur;
        wait_until_quiet();
        gain_word = CFG_DATA_W'($urandom());
        gain_word[GAIN_W-1:0] = ($urandom_range(3) == 0) ? GAIN_W'($urandom())
                                                         : GAIN_W'($urandom_range(32768));
        write_regs(CFG_DATA_W'($urandom()), gain_word);
        for (deep = 0; deep < DEEP_ITEMS; deep++)
        begin
            roll = $urandom_range(99);
            if (roll < 4)
            begin
                send_beat(CMD_UNUSED, DUR_W'($urandom()));
            end
            else if (roll < 30 && !pend_ok)
            begin
                dur = ($urandom_range(3) == 0) ? DUR_W'($urandom_range(40))
                                               : DUR_W'($urandom_range(800, 40));
                send_beat(ircbg_pkg::CMD_PUSH, dur);
            end
            else if (roll < 34 && pend_ok)
            begin
                send_beat(ircbg_pkg::CMD_PUSH, DUR_W'($urandom()));
            end
            else
            begin
                send_beat(ircbg_pkg::CMD_TICK, DUR_W'($urandom()));
            end
        end
    endtask

    // Receiver: random stalls, plus long hold-offs counted here.
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (stall_request > 0)
            begin
                stall_left = stall_request;
                stall_request = 0;
            end
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= quiet || ($urandom_range(99) >= 10);
            end
        end
    end

    // Compare each accepted result beat with the oldest expectation.
    always @(posedge clk)
    begin
        sample_beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (samples_due.size() == 0)
            begin
                note_mismatch("result beat with nothing expected", 1, 0);
            end
            else
            begin
                want = samples_due.pop_front();
                if (sample_left !== want.left_smp)
                    note_mismatch("sample_left", sample_left, want.left_smp);
                if (sample_right !== want.right_smp)
                    note_mismatch("sample_right", sample_right, want.right_smp);
                if (sample_valid !== want.active)
                    note_mismatch("sample_valid", sample_valid, want.active);
                if (is_mark !== want.mark)
                    note_mismatch("is_mark", is_mark, want.mark);
                if (need_duration !== want.need_dur)
                    note_mismatch("need_duration", need_duration, want.need_dur);
            end
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_before_start();
        test_preamble();
        test_segments();
        test_register_extremes();
        test_back_pressure();
        test_random_patterns();
        test_long_segment();
        wait_until_quiet();
        $display("covered %0d commands: %0d carrier and %0d silent samples, %0d starved ticks",
                 beats_sent, mark_ticks, silent_ticks, underruns);
        $display("with %0d segment loads and %0d register writes", seg_loads, reg_writes);
        if (errors == 0 && samples_due.size() == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Safety net against a hung handshake.
    initial
    begin
        #10_000_000;
        $display("timeout with %0d results outstanding", samples_due.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
